FILE: rtl/acetp_pkg.sv
// ----------------------------------------------------------------------------
// acetp_pkg: shared types and constants of the colour escape parser
// Parse phase encoding, action codes and the character codes that the
// parser recognises.
// ----------------------------------------------------------------------------
package acetp_pkg;

    // Parse phases, one-hot.
    typedef enum logic [7:0] {
        PH_IDLE   = 8'b0000_0001,
        PH_ESC    = 8'b0000_0010,
        PH_BRACK  = 8'b0000_0100,
        PH_ENDCLR = 8'b0000_1000,
        PH_ONE    = 8'b0001_0000,
        PH_SEMI   = 8'b0010_0000,
        PH_DIGIT  = 8'b0100_0000,
        PH_ENDCOL = 8'b1000_0000
    } phase_t;

    // Action codes of a result beat.
    localparam logic [1:0] ACT_NONE  = 2'd0;
    localparam logic [1:0] ACT_PRINT = 2'd1;
    localparam logic [1:0] ACT_BS    = 2'd2;
    localparam logic [1:0] ACT_NL    = 2'd3;

    // Character codes.
    localparam logic [7:0] CH_BS    = 8'h08;
    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_ESC   = 8'h1B;
    localparam logic [7:0] CH_BRACK = 8'h5B;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_ONE   = 8'h31;
    localparam logic [7:0] CH_THREE = 8'h33;
    localparam logic [7:0] CH_FOUR  = 8'h34;
    localparam logic [7:0] CH_SEMI  = 8'h3B;

    // Upper five bits shared by the digits '0' to '7'.
    localparam logic [4:0] DIGIT_HI = 5'b00110;

endpackage

FILE: rtl/ansi_color_escape_text_parser.sv
// ----------------------------------------------------------------------------
// ansi_color_escape_text_parser: colour escape parser for a text console
// Turns a stream of character bytes into console actions and coloured cells.
// ----------------------------------------------------------------------------
// Usage
//   Input beats arrive on the s_ group, one character byte per beat in
//   s_tdata[7:0]. Every input beat produces exactly one result beat on the
//   m_ group: an action code (none, print cell, backspace, new line) in
//   m_tuser and a 16-bit cell word in m_tdata; for a printed cell it holds
//   the colour attribute above the character byte, else it is zero.
//   Escape sequences ESC [ 0 x, ESC [ 1 ; 3 d x and ESC [ 1 ; 4 d x update
//   the attribute and give action none for each of their bytes.
//   The result of a byte accepted at one edge is registered and presented
//   on m_tdata and m_tuser right after that edge. The parser takes one
//   byte per cycle while the result register can take a beat; the parse
//   state updates in the same cycle as the byte is taken.
//   The result register parts the two sides: a new byte is taken whenever
//   the result register is empty or is being emptied in the same cycle, so
//   a receiver that holds m_tready low stalls the input after one beat.
//   Reset returns the parser to idle, clears the attribute and the
//   background flag, and empties the result register.
// ----------------------------------------------------------------------------
module ansi_color_escape_text_parser
    import acetp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] char_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [15:0] cell_word
    output logic [1:0]  m_tuser    // [1:0] action
);

    phase_t      phase_reg;
    phase_t      phase_next;
    logic        bg_reg;
    logic        bg_next;
    logic [7:0]  attr_reg;
    logic [7:0]  attr_next;
    logic [1:0]  act_next;
    logic [15:0] cell_next;

    logic        out_valid_reg;
    logic [1:0]  out_act_reg;
    logic [15:0] out_cell_reg;

    logic        s_fire;
    logic        is_digit;
    logic [2:0]  digit;

    // The result register can take a beat when it is empty or being drained.
    assign s_tready = !out_valid_reg || m_tready;
    assign s_fire   = s_tvalid && s_tready;

    assign is_digit = (s_tdata[7:3] == DIGIT_HI);
    assign digit    = s_tdata[2:0];

    // Next parse state and result of the byte on s_tdata.
    always_comb
    begin
        phase_next = PH_IDLE;
        bg_next    = bg_reg;
        attr_next  = attr_reg;
        act_next   = ACT_NONE;
        cell_next  = 16'h0000;
        unique case (phase_reg)
            PH_IDLE:
            begin
                phase_next = PH_IDLE;
                if (s_tdata == CH_BS)
                begin
                    act_next = ACT_BS;
                end
                else if (s_tdata == CH_NL)
                begin
                    act_next = ACT_NL;
                end
                else if (s_tdata == CH_ESC)
                begin
                    phase_next = PH_ESC;
                    bg_next    = 1'b0;
                end
                else
                begin
                    act_next  = ACT_PRINT;
                    cell_next = {attr_reg, s_tdata};
                end
            end
            PH_ESC:
            begin
                if (s_tdata == CH_BRACK)
                begin
                    phase_next = PH_BRACK;
                end
            end
            PH_BRACK:
            begin
                if (s_tdata == CH_ONE)
                begin
                    phase_next = PH_ONE;
                end
                else if (s_tdata == CH_ZERO)
                begin
                    attr_next  = 8'h00;
                    phase_next = PH_ENDCLR;
                end
            end
            PH_ONE:
            begin
                if (s_tdata == CH_SEMI)
                begin
                    phase_next = PH_SEMI;
                end
            end
            PH_SEMI:
            begin
                if (s_tdata == CH_THREE)
                begin
                    bg_next    = 1'b0;
                    phase_next = PH_DIGIT;
                end
                else if (s_tdata == CH_FOUR)
                begin
                    bg_next    = 1'b1;
                    phase_next = PH_DIGIT;
                end
            end
            PH_DIGIT:
            begin
                if (is_digit)
                begin
                    // Background sets the high nibble, foreground the low one.
                    if (bg_reg)
                    begin
                        attr_next = {1'b1, digit, attr_reg[3:0]};
                    end
                    else
                    begin
                        attr_next = {attr_reg[7:4], 1'b1, digit};
                    end
                    phase_next = PH_ENDCOL;
                end
            end
            PH_ENDCLR, PH_ENDCOL:
            begin
                // The final byte of a sequence is swallowed unchecked.
                phase_next = PH_IDLE;
            end
            default:
            begin
                phase_next = PH_IDLE;
            end
        endcase
    end

    // Parse state advances once per accepted beat.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            bg_reg    <= 1'b0;
            attr_reg  <= 8'h00;
        end
        else if (s_fire)
        begin
            phase_reg <= phase_next;
            bg_reg    <= bg_next;
            attr_reg  <= attr_next;
        end
    end

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s_fire)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_fire)
        begin
            out_act_reg  <= act_next;
            out_cell_reg <= cell_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_cell_reg;
    assign m_tuser  = out_act_reg;

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------

    // Bytes taken inside a sequence never give an action.
    a_seq_silent: assert property (@(posedge clk) disable iff (!rst_n)
        (s_fire && phase_reg != PH_IDLE) |=> (out_act_reg == ACT_NONE))
        else $error("byte inside an escape sequence produced an action");

    // The cell word is zero unless a cell is printed.
    a_cell_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_act_reg != ACT_PRINT) |-> (out_cell_reg == 16'h0000))
        else $error("cell word not zero for a non-print action");

    // The attribute only moves when a beat is taken.
    a_attr_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !s_fire |=> $stable(attr_reg))
        else $error("attribute changed without an input beat");

    // A printed cell carries the attribute held when its byte was taken.
    a_cell_attr: assert property (@(posedge clk) disable iff (!rst_n)
        (s_fire && phase_reg == PH_IDLE && act_next == ACT_PRINT)
        |=> (out_cell_reg[15:8] == $past(attr_reg)))
        else $error("printed cell carries the wrong attribute");

endmodule
